@@ rtl/core/quadratic_root_solver_top_assert.svh @@
// ---------------------------------------------------------------------------
// Quadratic root solver assertion macros
// Shared property forms for the checkers of the solver.
// ---------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_TOP_ASSERT_SVH

`define QRS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define QRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`define QRS_ASSERT_AFTER_RESET(lbl, clk, rst, cons, msg) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/qrs_pkg.sv @@
// ---------------------------------------------------------------------------
// Quadratic root solver package
// Result kinds, fixed output scaling and the flags carried down the pipeline.
// ---------------------------------------------------------------------------
package qrs_pkg;

   localparam int OUT_FRAC_BITS = 16;
   localparam int OUT_WIDTH     = 32;
   localparam int MAX_EFF_WIDTH = 30;

   typedef enum logic [1:0] {
      KIND_TWO_REAL   = 2'd0,
      KIND_DOUBLE     = 2'd1,
      KIND_COMPLEX    = 2'd2,
      KIND_DEGENERATE = 2'd3
   } kind_type;

   typedef struct packed {
      logic zero;
      logic cplx;
      logic neg1;
      logic neg2;
   } flags_type;

endpackage

@@ rtl/core/qrs_req_if.sv @@
// ---------------------------------------------------------------------------
// Quadratic root solver request channel
// Valid/ready channel carrying one set of coefficients per beat.
// ---------------------------------------------------------------------------
interface qrs_req_if #(
   parameter int COEF_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COEF_WIDTH-1:0] coef_a;
   logic signed [COEF_WIDTH-1:0] coef_b;
   logic signed [COEF_WIDTH-1:0] coef_c;

   modport source (output valid, coef_a, coef_b, coef_c, input ready);
   modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

@@ rtl/core/qrs_rsp_if.sv @@
// ---------------------------------------------------------------------------
// Quadratic root solver response channel
// Valid/ready channel carrying one result per beat.
// ---------------------------------------------------------------------------
interface qrs_rsp_if;
   import qrs_pkg::*;
   logic               valid;
   logic               ready;
   kind_type           root_kind;
   logic signed [31:0] first_value;
   logic signed [31:0] second_value;
   logic               saturated;

   modport source (output valid, root_kind, first_value, second_value, saturated,
                   input ready);
   modport sink (input valid, root_kind, first_value, second_value, saturated,
                 output ready);
endinterface

@@ rtl/core/quadratic_root_solver_top.sv @@
// Throughput: one request beat per cycle; the whole pipeline holds while a
// response beat waits, so request ready follows the response side.
// Reset clears every stage valid bit; the data registers are not reset.
// ---------------------------------------------------------------------------
// Quadratic root solver top level
// Discriminant multipliers, a row of square root cells and a row of
// divider cells, then clamping into the response register.
// ---------------------------------------------------------------------------
module quadratic_root_solver_top #(
   parameter int COEF_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   qrs_req_if.sink   req_chan,
   qrs_rsp_if.source rsp_chan
);
   import qrs_pkg::*;

   localparam int EW  = (COEF_WIDTH > MAX_EFF_WIDTH) ? MAX_EFF_WIDTH : COEF_WIDTH;
   localparam int SQW = EW + 1;
   localparam int DW  = 2 * EW + 3;
   localparam int NSW = EW + 3;
   localparam int NMW = EW + 2 + OUT_FRAC_BITS;
   localparam int DVW = EW + 1;
   localparam int MW  = (NMW > OUT_WIDTH + 1) ? NMW : OUT_WIDTH + 1;

   logic adv;
   logic out_valid_ff;

   assign adv = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // Products
   logic                   v1_ff;
   logic signed [EW-1:0]   a1_ff, b1_ff;
   logic signed [2*EW-1:0] bb1_ff, ac1_ff, bb1_in, ac1_in;
   logic signed [EW-1:0]   a_s, b_s, c_s;

   always_comb begin
      a_s    = req_chan.coef_a[EW-1:0];
      b_s    = req_chan.coef_b[EW-1:0];
      c_s    = req_chan.coef_c[EW-1:0];
      bb1_in = b_s * b_s;
      ac1_in = a_s * c_s;
   end

   // Discriminant
   logic                  v2_ff;
   logic signed [EW-1:0]  a2_ff, b2_ff;
   logic [2*SQW-1:0]      rad2_ff, rad2_in;
   flags_type             flags2_ff, flags2_in;
   logic signed [DW-1:0]  disc, disc_mag;

   always_comb begin
      disc           = DW'(bb1_ff) - (DW'(ac1_ff) <<< 2);
      disc_mag       = disc[DW-1] ? -disc : disc;
      rad2_in        = disc_mag[2*SQW-1:0];
      flags2_in      = '0;
      flags2_in.zero = (a1_ff == '0);
      flags2_in.cplx = disc[DW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff     <= a_s;
         b1_ff     <= b_s;
         bb1_ff    <= bb1_in;
         ac1_ff    <= ac1_in;
         a2_ff     <= a1_ff;
         b2_ff     <= b1_ff;
         rad2_ff   <= rad2_in;
         flags2_ff <= flags2_in;
      end
   end

   // Square root row
   logic                 sq_valid [SQW+1];
   logic [2*SQW-1:0]     sq_rad   [SQW+1];
   logic [SQW+1:0]       sq_rem   [SQW+1];
   logic [SQW-1:0]       sq_root  [SQW+1];
   logic signed [EW-1:0] sq_a     [SQW+1];
   logic signed [EW-1:0] sq_b     [SQW+1];
   flags_type            sq_flags [SQW+1];

   assign sq_valid[0] = v2_ff;
   assign sq_rad[0]   = rad2_ff;
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_a[0]     = a2_ff;
   assign sq_b[0]     = b2_ff;
   assign sq_flags[0] = flags2_ff;

   for (genvar i = 0; i < SQW; i++) begin : g_sqrt
      qrs_sqrt_cell #(.SQW(SQW), .EW(EW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (sq_valid[i]),
         .in_rad    (sq_rad[i]),
         .in_rem    (sq_rem[i]),
         .in_root   (sq_root[i]),
         .in_a      (sq_a[i]),
         .in_b      (sq_b[i]),
         .in_flags  (sq_flags[i]),
         .out_valid (sq_valid[i+1]),
         .out_rad   (sq_rad[i+1]),
         .out_rem   (sq_rem[i+1]),
         .out_root  (sq_root[i+1]),
         .out_a     (sq_a[i+1]),
         .out_b     (sq_b[i+1]),
         .out_flags (sq_flags[i+1])
      );
   end

   // Numerators and divisor
   logic                  v3_ff;
   logic [NMW-1:0]        num3_ff [2];
   logic [NMW-1:0]        num3_in [2];
   logic [DVW-1:0]        div3_ff, div3_in;
   flags_type             flags3_ff, flags3_in;
   logic signed [NSW-1:0] nb, ns, n1, n2, m1, m2, na;

   always_comb begin
      nb = -NSW'(sq_b[SQW]);
      ns = NSW'({1'b0, sq_root[SQW]});
      if (sq_flags[SQW].cplx) begin
         n1 = nb;
         n2 = ns;
      end else begin
         n1 = nb - ns;
         n2 = nb + ns;
      end
      m1 = n1[NSW-1] ? -n1 : n1;
      m2 = n2[NSW-1] ? -n2 : n2;
      na = NSW'(sq_a[SQW]);
      na = na[NSW-1] ? -na : na;
      num3_in[0]     = {m1[NSW-2:0], {OUT_FRAC_BITS{1'b0}}};
      num3_in[1]     = {m2[NSW-2:0], {OUT_FRAC_BITS{1'b0}}};
      div3_in        = {na[EW-1:0], 1'b0};
      flags3_in      = sq_flags[SQW];
      flags3_in.neg1 = n1[NSW-1] ^ sq_a[SQW][EW-1];
      flags3_in.neg2 = n2[NSW-1] ^ sq_a[SQW][EW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= sq_valid[SQW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num3_ff   <= num3_in;
         div3_ff   <= div3_in;
         flags3_ff <= flags3_in;
      end
   end

   // Divider row
   logic           dv_valid [NMW+1];
   logic [NMW-1:0] dv_num   [NMW+1][2];
   logic [DVW:0]   dv_rem   [NMW+1][2];
   logic [DVW-1:0] dv_div   [NMW+1];
   flags_type      dv_flags [NMW+1];

   assign dv_valid[0]  = v3_ff;
   assign dv_num[0]    = num3_ff;
   assign dv_rem[0][0] = '0;
   assign dv_rem[0][1] = '0;
   assign dv_div[0]    = div3_ff;
   assign dv_flags[0]  = flags3_ff;

   for (genvar i = 0; i < NMW; i++) begin : g_div
      qrs_div_cell #(.NMW(NMW), .DVW(DVW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (dv_valid[i]),
         .in_num    (dv_num[i]),
         .in_rem    (dv_rem[i]),
         .in_div    (dv_div[i]),
         .in_flags  (dv_flags[i]),
         .out_valid (dv_valid[i+1]),
         .out_num   (dv_num[i+1]),
         .out_rem   (dv_rem[i+1]),
         .out_div   (dv_div[i+1]),
         .out_flags (dv_flags[i+1])
      );
   end

   // Sign, clamp and classify
   kind_type           kind_ff, kind_in;
   logic signed [31:0] first_ff, first_in, second_ff, second_in;
   logic               sat_ff, sat_in;
   logic [MW-1:0]      mag1, mag2;
   logic signed [MW:0] q1, q2;
   logic               hi1, lo1, hi2, lo2;
   flags_type          fo;

   always_comb begin
      fo   = dv_flags[NMW];
      mag1 = MW'(dv_num[NMW][0]);
      mag2 = MW'(dv_num[NMW][1]);
      q1   = fo.neg1 ? -{1'b0, mag1} : {1'b0, mag1};
      q2   = fo.neg2 ? -{1'b0, mag2} : {1'b0, mag2};
      hi1  = !fo.neg1 && (mag1 > MW'(33'h0_7FFF_FFFF));
      lo1  = fo.neg1 && (mag1 > MW'(33'h0_8000_0000));
      hi2  = !fo.neg2 && (mag2 > MW'(33'h0_7FFF_FFFF));
      lo2  = fo.neg2 && (mag2 > MW'(33'h0_8000_0000));
      first_in  = hi1 ? 32'sh7FFF_FFFF : (lo1 ? 32'sh8000_0000 : q1[31:0]);
      second_in = hi2 ? 32'sh7FFF_FFFF : (lo2 ? 32'sh8000_0000 : q2[31:0]);
      sat_in    = hi1 || lo1 || hi2 || lo2;
      if (fo.zero) begin
         kind_in   = KIND_DEGENERATE;
         first_in  = '0;
         second_in = '0;
         sat_in    = 1'b0;
      end else if (fo.cplx) begin
         kind_in = KIND_COMPLEX;
      end else if (q1 == q2) begin
         kind_in = KIND_DOUBLE;
      end else begin
         kind_in = KIND_TWO_REAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= dv_valid[NMW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind_ff   <= kind_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         sat_ff    <= sat_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.root_kind    = kind_ff;
   assign rsp_chan.first_value  = first_ff;
   assign rsp_chan.second_value = second_ff;
   assign rsp_chan.saturated    = sat_ff;
endmodule

@@ rtl/core/qrs_sqrt_cell.sv @@
// ---------------------------------------------------------------------------
// Quadratic root solver square root cell
// One restoring step of the integer square root, with its operands passed on.
// ---------------------------------------------------------------------------
module qrs_sqrt_cell #(
   parameter int SQW = 17,
   parameter int EW  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [2*SQW-1:0]      in_rad,
   input  logic [SQW+1:0]        in_rem,
   input  logic [SQW-1:0]        in_root,
   input  logic signed [EW-1:0]  in_a,
   input  logic signed [EW-1:0]  in_b,
   input  qrs_pkg::flags_type    in_flags,
   output logic                  out_valid,
   output logic [2*SQW-1:0]      out_rad,
   output logic [SQW+1:0]        out_rem,
   output logic [SQW-1:0]        out_root,
   output logic signed [EW-1:0]  out_a,
   output logic signed [EW-1:0]  out_b,
   output qrs_pkg::flags_type    out_flags
);
   import qrs_pkg::*;

   logic                 valid_ff;
   logic [2*SQW-1:0]     rad_ff, rad_in;
   logic [SQW+1:0]       rem_ff, rem_in, rem_sh, trial;
   logic [SQW-1:0]       root_ff, root_in;
   logic signed [EW-1:0] a_ff, b_ff;
   flags_type            flags_ff;
   logic                 ge;

   always_comb begin
      rem_sh  = {in_rem[SQW-1:0], in_rad[2*SQW-1 -: 2]};
      trial   = {in_root, 2'b01};
      ge      = rem_sh >= trial;
      rem_in  = ge ? rem_sh - trial : rem_sh;
      root_in = {in_root[SQW-2:0], ge};
      rad_in  = in_rad << 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff   <= rad_in;
         rem_ff   <= rem_in;
         root_ff  <= root_in;
         a_ff     <= in_a;
         b_ff     <= in_b;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_flags = flags_ff;
endmodule

@@ rtl/core/qrs_div_cell.sv @@
// ---------------------------------------------------------------------------
// Quadratic root solver divider cell
// One restoring division step for both quotient lanes against a shared divisor.
// ---------------------------------------------------------------------------
module qrs_div_cell #(
   parameter int NMW = 34,
   parameter int DVW = 17
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [NMW-1:0]     in_num [2],
   input  logic [DVW:0]       in_rem [2],
   input  logic [DVW-1:0]     in_div,
   input  qrs_pkg::flags_type in_flags,
   output logic               out_valid,
   output logic [NMW-1:0]     out_num [2],
   output logic [DVW:0]       out_rem [2],
   output logic [DVW-1:0]     out_div,
   output qrs_pkg::flags_type out_flags
);
   import qrs_pkg::*;

   logic           valid_ff;
   logic [NMW-1:0] num_ff [2];
   logic [NMW-1:0] num_in [2];
   logic [DVW:0]   rem_ff [2];
   logic [DVW:0]   rem_in [2];
   logic [DVW-1:0] div_ff;
   flags_type      flags_ff;

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DVW:0] sh;
      logic         ge;
      always_comb begin
         sh        = {in_rem[l][DVW-1:0], in_num[l][NMW-1]};
         ge        = sh >= {1'b0, in_div};
         rem_in[l] = ge ? sh - {1'b0, in_div} : sh;
         num_in[l] = {in_num[l][NMW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff   <= num_in;
         rem_ff   <= rem_in;
         div_ff   <= in_div;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_num   = num_ff;
   assign out_rem   = rem_ff;
   assign out_div   = div_ff;
   assign out_flags = flags_ff;
endmodule

@@ rtl/core/qrs_checker.sv @@
// ---------------------------------------------------------------------------
// Quadratic root solver checker
// Port-level properties of the response beats, bound to the top level.
// ---------------------------------------------------------------------------
`include "quadratic_root_solver_top_assert.svh"

module qrs_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         root_kind,
   input logic signed [31:0] first_value,
   input logic signed [31:0] second_value,
   input logic               saturated
);
   import qrs_pkg::*;

   `QRS_ASSERT_AFTER_RESET(a_idle_after_reset, clock, reset, !rsp_valid, "response beat after reset")
   `QRS_ASSERT_NOW(a_degenerate_zero, clock, reset, rsp_valid && root_kind == KIND_DEGENERATE, first_value == 0 && second_value == 0 && !saturated, "degenerate beat not zero")
   `QRS_ASSERT_NOW(a_double_equal, clock, reset, rsp_valid && root_kind == KIND_DOUBLE, first_value == second_value, "double root values differ")
   `QRS_ASSERT_NOW(a_two_distinct, clock, reset, rsp_valid && root_kind == KIND_TWO_REAL && !saturated, first_value != second_value, "two real roots are equal")
   `QRS_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(first_value) && $stable(second_value), "stalled beat changed")
endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .root_kind    (rsp_chan.root_kind),
   .first_value  (rsp_chan.first_value),
   .second_value (rsp_chan.second_value),
   .saturated    (rsp_chan.saturated)
);

@@ verif/quadratic_root_solver_top_tb.sv @@
// ---------------------------------------------------------------------------
// Quadratic root solver testbench
// Drives coefficient sets through the request channel and checks every
// response beat against a fixed-point prediction of the roots.
// ---------------------------------------------------------------------------
module quadratic_root_solver_top_tb;
   import qrs_pkg::*;

   localparam int CW         = 16;
   localparam int LATENCY    = 2 * CW + 23;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic signed [CW-1:0] a;
      logic signed [CW-1:0] b;
      logic signed [CW-1:0] c;
   } coef_set_type;

   typedef struct {
      kind_type           kind;
      logic signed [31:0] first;
      logic signed [31:0] second;
      logic               sat;
   } roots_type;

   logic clock;
   logic reset;

   qrs_req_if #(.COEF_WIDTH(CW)) req_chan ();
   qrs_rsp_if                    rsp_chan ();

   quadratic_root_solver_top #(.COEF_WIDTH(CW)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   coef_set_type pending_sets[$];
   roots_type    expected_roots[$];
   int        send_idle_pct;
   int        recv_idle_pct;
   int        hold_off_cycles;
   bit        send_paused;
   int        mismatches;
   int        beats_checked;
   int        idle_cycles;
   bit        timed_out;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [31:0] clamp_q16(longint v, inout logic sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic roots_type solve_roots(coef_set_type cs);
      roots_type       r;
      longint          a, b, c, disc, den, q1, q2;
      longint unsigned s;
      logic            sat;
      a   = longint'(cs.a);
      b   = longint'(cs.b);
      c   = longint'(cs.c);
      sat = 1'b0;
      if (a == 0) begin
         r.kind   = KIND_DEGENERATE;
         r.first  = '0;
         r.second = '0;
         r.sat    = 1'b0;
         return r;
      end
      disc = b * b - 4 * a * c;
      den  = 2 * a;
      if (disc >= 0) begin
         s  = root_floor(disc);
         q1 = ((-b - longint'(s)) * 65536) / den;
         q2 = ((-b + longint'(s)) * 65536) / den;
         r.kind = (q1 == q2) ? KIND_DOUBLE : KIND_TWO_REAL;
      end else begin
         s  = root_floor(-disc);
         q1 = ((-b) * 65536) / den;
         q2 = (longint'(s) * 65536) / den;
         r.kind = KIND_COMPLEX;
      end
      r.first  = clamp_q16(q1, sat);
      r.second = clamp_q16(q2, sat);
      r.sat    = sat;
      return r;
   endfunction

   task automatic add_set(int a, int b, int c);
      coef_set_type cs;
      cs.a = CW'(a);
      cs.b = CW'(b);
      cs.c = CW'(c);
      pending_sets.push_back(cs);
   endtask

   task automatic add_random_set();
      int a, b, c;
      case ($urandom_range(0, 5))
         0: begin
            // Perfect square: a double root at -b/2a, unless c overflows the coefficient width.
            a = $urandom_range(1, 200) * ($urandom_range(0, 1) ? 1 : -1);
            b = 2 * a * ($urandom_range(0, 40) - 20);
            c = (b / (2 * a)) * (b / (2 * a)) * a;
         end
         1: begin
            a = $urandom_range(0, 3) - 1;
            b = $urandom();
            c = $urandom();
         end
         2: begin
            a = $urandom_range(0, 511) - 256;
            b = $urandom_range(0, 511) - 256;
            c = $urandom_range(0, 511) - 256;
         end
         default: begin
            a = $urandom();
            b = $urandom();
            c = $urandom();
         end
      endcase
      add_set(a, b, c);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.coef_a <= '0;
         req_chan.coef_b <= '0;
         req_chan.coef_c <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_roots.push_back(solve_roots('{req_chan.coef_a, req_chan.coef_b,
                                                   req_chan.coef_c}));
            void'(pending_sets.pop_front());
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (req_chan.valid && req_chan.ready && pending_sets.size() == 0) begin
               req_chan.valid <= 1'b0;
            end else if (pending_sets.size() != 0 && !send_paused &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
               req_chan.valid  <= 1'b1;
               req_chan.coef_a <= pending_sets[0].a;
               req_chan.coef_b <= pending_sets[0].b;
               req_chan.coef_c <= pending_sets[0].c;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      roots_type exp_r;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            beats_checked++;
            if (expected_roots.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected response beat: kind %0d first %0d second %0d",
                           rsp_chan.root_kind, rsp_chan.first_value,
                           rsp_chan.second_value);
            end else begin
               exp_r = expected_roots.pop_front();
               if (rsp_chan.root_kind !== exp_r.kind ||
                   rsp_chan.first_value !== exp_r.first ||
                   rsp_chan.second_value !== exp_r.second ||
                   rsp_chan.saturated !== exp_r.sat) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                              exp_r.kind, exp_r.first, exp_r.second, exp_r.sat,
                              rsp_chan.root_kind, rsp_chan.first_value,
                              rsp_chan.second_value, rsp_chan.saturated);
               end
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_chan.ready  <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (hold_off_cycles == 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding",
                     expected_roots.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic drain();
      while (pending_sets.size() != 0 || req_chan.valid || expected_roots.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      reset           = 1'b1;
      send_idle_pct   = 27;
      recv_idle_pct   = 55;
      hold_off_cycles = 0;
      send_paused     = 1'b0;
      mismatches      = 0;
      beats_checked   = 0;
      idle_cycles     = 0;
      req_chan.valid  = 1'b0;
      req_chan.coef_a = '0;
      req_chan.coef_b = '0;
      req_chan.coef_c = '0;
      rsp_chan.ready  = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      add_set(0, 100, -7);
      add_set(0, 0, 0);
      add_set(256, 0, -256);
      add_set(256, -512, 256);
      add_set(256, 0, 256);
      add_set(-256, 0, 256);
      add_set(1, 0, 0);
      add_set(1, 32767, 0);
      add_set(1, -32768, 0);
      add_set(-1, -32768, 32767);
      add_set(-32768, -32768, -32768);
      add_set(32767, 32767, 32767);
      add_set(-32768, 32767, 32767);
      add_set(32767, -32768, -32768);
      add_set(1, 1, 32767);
      add_set(-1, 1, 32767);
      add_set(3, -7, 2);
      add_set(-5, 11, 0);
      add_set(1, 2, 1);
      add_set(-1, 0, -32768);
      add_set(1, 32767, -32768);
      add_set(1, 32767, -20000);
      drain();

      // Long receiver hold-off while the sender keeps offering beats.
      hold_off_cycles = 300;
      repeat (200) add_random_set();
      drain();

      repeat (600) add_random_set();
      drain();
      send_idle_pct = 55;
      recv_idle_pct = 27;
      repeat (600) add_random_set();
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (600) add_random_set();
      drain();
      repeat (LATENCY + 10) @(posedge clock);

      $display("Checked %0d response beats over directed, random and stall phases.",
               beats_checked);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/qrs_pkg.sv
rtl/core/qrs_req_if.sv
rtl/core/qrs_rsp_if.sv
rtl/core/qrs_sqrt_cell.sv
rtl/core/qrs_div_cell.sv
rtl/core/quadratic_root_solver_top.sv
rtl/core/qrs_checker.sv
verif/quadratic_root_solver_top_tb.sv
